/* rtl/vrp_pkg.sv */
// Shared constants, types and the sine table of the vertex rotate/project unit.
`default_nettype none

package vrp_pkg;

  // Build-time sizing
  localparam int ANGLE_BITS = 10;
  localparam int COORD_BITS = 12;

  // Fixed field widths of the ports
  localparam int VERTEX_W   = 12;
  localparam int SCREEN_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int ANGLE_W    = 10;
  localparam int OFFSET_W   = 10;
  localparam int DEPTH_W    = 12;

  // Fixed-point formats
  localparam int FRAC_BITS  = 14;
  localparam int TRIG_W     = 16;
  localparam int PROJ_SHIFT = 6;
  localparam int QUARTER    = 1 << (ANGLE_BITS - 2);

  // Rotated coordinate (Q14), product, depth, numerator, quotient, remainder widths
  localparam int QW     = COORD_BITS + 18;
  localparam int PW     = QW + TRIG_W;
  localparam int ZW     = ((QW > DEPTH_W + FRAC_BITS) ? QW : DEPTH_W + FRAC_BITS) + 2;
  localparam int NW     = ZW + 12;
  localparam int QUO_W  = SCREEN_W + 1;
  localparam int RW     = ZW + QUO_W;

  // Input queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = CFG_IDX_W'(5);

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(80);

  localparam logic signed [SCREEN_W-1:0] SAT_MAX = {1'b0, {(SCREEN_W-1){1'b1}}};
  localparam logic signed [SCREEN_W-1:0] SAT_MIN = {1'b1, {(SCREEN_W-1){1'b0}}};

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset_x;
    logic [OFFSET_W-1:0] offset_y;
    logic [DEPTH_W-1:0]  depth;
  } view_t;

  typedef struct packed {
    logic signed [SCREEN_W-1:0] screen_x;
    logic signed [SCREEN_W-1:0] screen_y;
    logic                       behind_viewer;
    logic                       clipped;
  } pixel_t;

  // Taylor term divisors (2n)(2n+1)
  typedef logic [63:0] div_tab_t [1:12];
  localparam div_tab_t TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
                                      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

  // Quarter-wave sine in Q1.14, evaluated at elaboration
  typedef logic [FRAC_BITS:0] sine_rom_t [QUARTER+1];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         rom;
    logic [63:0]       th;
    logic [63:0]       th2;
    logic [63:0]       term;
    logic signed [63:0] sum;
    logic signed [63:0] e;
    for (int m = 0; m <= QUARTER; m++) begin
      th   = (64'(m) * 64'd1686629713) >> (ANGLE_BITS - 2);
      th2  = (th * th) >> 30;
      term = th;
      sum  = signed'(th);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * th2) >> 30) / TAYLOR_DIV[n];
        if (n[0]) sum = sum - signed'(term);
        else      sum = sum + signed'(term);
      end
      if (sum < 0) sum = 0;
      e = (sum + 64'sd32768) >>> 16;
      if (e > 64'sd16384) e = 64'sd16384;
      rom[m] = (FRAC_BITS+1)'(e);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  localparam logic [ANGLE_BITS-2:0] QUARTER_IDX   = (ANGLE_BITS-1)'(QUARTER);
  localparam logic [ANGLE_BITS-1:0] QUARTER_ANGLE = ANGLE_BITS'(QUARTER);

  // Full-wave sine from the quarter table (mirror odd quadrants, negate upper half)
  function automatic logic signed [TRIG_W-1:0] sine_of(input logic [ANGLE_BITS-1:0] a);
    logic [ANGLE_BITS-2:0]    idx;
    logic signed [TRIG_W-1:0] v;
    if (a[ANGLE_BITS-2]) idx = QUARTER_IDX - {1'b0, a[ANGLE_BITS-3:0]};
    else                 idx = {1'b0, a[ANGLE_BITS-3:0]};
    v = signed'(TRIG_W'(SINE_ROM[idx]));
    return a[ANGLE_BITS-1] ? -v : v;
  endfunction

  function automatic trig_t trig_of(input logic [ANGLE_BITS-1:0] a);
    trig_t t;
    t.sin_v = sine_of(a);
    t.cos_v = sine_of(a + QUARTER_ANGLE);
    return t;
  endfunction

endpackage

`default_nettype wire

/* rtl/vrp_vertex_if.sv */
// Vertex input channel.
`default_nettype none

interface vrp_vertex_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vrp_pkg::VERTEX_W-1:0]  vertex_x;
  logic signed [vrp_pkg::VERTEX_W-1:0]  vertex_y;
  logic signed [vrp_pkg::VERTEX_W-1:0]  vertex_z;

  modport source (output valid, vertex_x, vertex_y, vertex_z, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, output ready);
endinterface

`default_nettype wire

/* rtl/vrp_pixel_if.sv */
// Projected point output channel.
`default_nettype none

interface vrp_pixel_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vrp_pkg::SCREEN_W-1:0]  screen_x;
  logic signed [vrp_pkg::SCREEN_W-1:0]  screen_y;
  logic                                 behind_viewer;
  logic                                 clipped;

  modport source (output valid, screen_x, screen_y, behind_viewer, clipped, input ready);
  modport sink   (input valid, screen_x, screen_y, behind_viewer, clipped, output ready);
endinterface

`default_nettype wire

/* rtl/vrp_cfg_if.sv */
// Register write channel.
`default_nettype none

interface vrp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [vrp_pkg::CFG_IDX_W-1:0]      index;
  logic [vrp_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/vertex_rotate_project_unit.sv */
// Top level of the vertex rotate/project unit: registers, trig lookup, datapath.
//
//  channel   dir   handshake      word
//  vtx_i     in    valid/ready    vertex_x, vertex_y, vertex_z (12b signed)
//  pix_o     out   valid/ready    screen_x, screen_y (16b signed), behind_viewer, clipped
//  cfg_i     in    valid/ready    index (3b), data (12b); always ready
//
//  One vertex per cycle sustained while pix_o is not stalled; a result passes through the
//  queue output register, the X, Y and Z rotations, projection, divider and output register.
//  The divide is a 17-stage restoring pipeline, one quotient bit per stage per lane.
//  A 4-word input queue decouples the input from the datapath; pix_o stalls freeze
//  the whole datapath while the queue keeps taking vertices until it is full.
//  Reset clears control and the registers (depth offset to 80); angle changes reach
//  the sine/cosine registers in the cycle after the write.
`default_nettype none

module vertex_rotate_project_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  vrp_vertex_if.sink  vtx_i,
  vrp_pixel_if.source pix_o,
  vrp_cfg_if.sink     cfg_i
);

  logic [vrp_pkg::ANGLE_W-1:0] angle_x_q, angle_y_q, angle_z_q;
  vrp_pkg::view_t              view_q;
  vrp_pkg::trig_t              trig_x_q, trig_y_q, trig_z_q;
  logic                        en;

  logic                        fv;
  vrp_pkg::vertex_t            fvtx;
  logic                        v1, v2, v3, v4;
  logic signed [vrp_pkg::QW-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
  vrp_pkg::pixel_t             pix;

  assign cfg_i.ready = 1'b1;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_x_q       <= '0;
      angle_y_q       <= '0;
      angle_z_q       <= '0;
      view_q.offset_x <= '0;
      view_q.offset_y <= '0;
      view_q.depth    <= vrp_pkg::DEPTH_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        vrp_pkg::REG_ANGLE_X:  angle_x_q       <= cfg_i.data[vrp_pkg::ANGLE_W-1:0];
        vrp_pkg::REG_ANGLE_Y:  angle_y_q       <= cfg_i.data[vrp_pkg::ANGLE_W-1:0];
        vrp_pkg::REG_ANGLE_Z:  angle_z_q       <= cfg_i.data[vrp_pkg::ANGLE_W-1:0];
        vrp_pkg::REG_OFFSET_X: view_q.offset_x <= cfg_i.data[vrp_pkg::OFFSET_W-1:0];
        vrp_pkg::REG_OFFSET_Y: view_q.offset_y <= cfg_i.data[vrp_pkg::OFFSET_W-1:0];
        vrp_pkg::REG_DEPTH:    view_q.depth    <= cfg_i.data[vrp_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Sine/cosine per axis, looked up from the quarter-wave table
  always_ff @(posedge clk_i) begin
    trig_x_q <= vrp_pkg::trig_of(vrp_pkg::ANGLE_BITS'(angle_x_q));
    trig_y_q <= vrp_pkg::trig_of(vrp_pkg::ANGLE_BITS'(angle_y_q));
    trig_z_q <= vrp_pkg::trig_of(vrp_pkg::ANGLE_BITS'(angle_z_q));
  end

  // Datapath advances unless a finished word is waiting
  assign en = !pix_o.valid || pix_o.ready;

  vrp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vtx_i    (vtx_i),
    .en_i     (en),
    .valid_o  (fv),
    .vertex_o (fvtx)
  );

  // About X: (y,z)
  vrp_rotate u_rot_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (fv),
    .a_i (fvtx.y), .b_i (fvtx.z), .c_i (fvtx.x), .trig_i (trig_x_q),
    .valid_o (v1), .a_o (y1), .b_o (z1), .c_o (x1)
  );

  // About Y: (x,z)
  vrp_rotate u_rot_y (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (v1),
    .a_i (x1), .b_i (z1), .c_i (y1), .trig_i (trig_y_q),
    .valid_o (v2), .a_o (x2), .b_o (z2), .c_o (y2)
  );

  // About Z: (x,y)
  vrp_rotate u_rot_z (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (v2),
    .a_i (x2), .b_i (y2), .c_i (z2), .trig_i (trig_z_q),
    .valid_o (v3), .a_o (x3), .b_o (y3), .c_o (z3)
  );

  vrp_project u_project (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3),
    .px_i    (x3),
    .py_i    (y3),
    .pz_i    (z3),
    .view_i  (view_q),
    .valid_o (v4),
    .pixel_o (pix)
  );

  assign pix_o.valid         = v4;
  assign pix_o.screen_x      = pix.screen_x;
  assign pix_o.screen_y      = pix.screen_y;
  assign pix_o.behind_viewer = pix.behind_viewer;
  assign pix_o.clipped       = pix.clipped;

`ifndef SYNTHESIS
  // Points behind the viewer come out as zeros and never clip
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.behind_viewer) |->
      (pix_o.screen_x == '0 && pix_o.screen_y == '0 && !pix_o.clipped))
    else $error("behind-viewer word not zeroed");

  // A clipped word has at least one coordinate at a range limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.clipped) |->
      (pix_o.screen_x == vrp_pkg::SAT_MAX || pix_o.screen_x == vrp_pkg::SAT_MIN ||
       pix_o.screen_y == vrp_pkg::SAT_MAX || pix_o.screen_y == vrp_pkg::SAT_MIN))
    else $error("clip flag without saturated coordinate");

  // Zero angle gives sine 0 and cosine one in Q14
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (angle_x_q == '0) |=> (trig_x_q.sin_v == '0 && trig_x_q.cos_v == 16'sd16384))
    else $error("trig lookup wrong at zero angle");
`endif

endmodule

`default_nettype wire

/* rtl/vrp_front.sv */
// Front end: accepts vertices, converts them to Q14 and queues them for the datapath.
`default_nettype none

module vrp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  vrp_vertex_if.sink       vtx_i,
  input  logic             en_i,
  output logic             valid_o,
  output vrp_pkg::vertex_t vertex_o
);

  vrp_pkg::vertex_t                slot_q [vrp_pkg::QUEUE_DEPTH];
  logic [vrp_pkg::QUEUE_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [vrp_pkg::QUEUE_AW:0]      count_q;
  logic                            push, pop;
  vrp_pkg::vertex_t                in_word;

  // Field to Q14: sign taken from the configured coordinate width
  function automatic logic signed [vrp_pkg::QW-1:0] to_q14(
    input logic [vrp_pkg::VERTEX_W-1:0] raw
  );
    logic signed [vrp_pkg::COORD_BITS-1:0] c;
    c = signed'(vrp_pkg::COORD_BITS'(raw));
    return vrp_pkg::QW'(c) <<< vrp_pkg::FRAC_BITS;
  endfunction

  assign vtx_i.ready = (count_q != (vrp_pkg::QUEUE_AW+1)'(vrp_pkg::QUEUE_DEPTH));
  assign push        = vtx_i.valid && vtx_i.ready;
  assign pop         = en_i && (count_q != '0);

  always_comb begin
    in_word.x = to_q14(vtx_i.vertex_x);
    in_word.y = to_q14(vtx_i.vertex_y);
    in_word.z = to_q14(vtx_i.vertex_z);
  end

  // Queue control and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      valid_o  <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (!push && pop) count_q <= count_q - 1'b1;
      if (en_i) valid_o <= (count_q != '0);
    end
  end

  // Queue storage and output word
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= in_word;
    if (en_i) vertex_o <= slot_q[rd_ptr_q];
  end

endmodule

`default_nettype wire

/* rtl/vrp_rotate.sv */
// One plane rotation: (a,b) -> (a*c - b*s, a*s + b*c), rounded to Q14, two stages.
`default_nettype none

module vrp_rotate (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [vrp_pkg::QW-1:0]    a_i,
  input  logic signed [vrp_pkg::QW-1:0]    b_i,
  input  logic signed [vrp_pkg::QW-1:0]    c_i,
  input  vrp_pkg::trig_t                   trig_i,
  output logic                             valid_o,
  output logic signed [vrp_pkg::QW-1:0]    a_o,
  output logic signed [vrp_pkg::QW-1:0]    b_o,
  output logic signed [vrp_pkg::QW-1:0]    c_o
);

  logic                                  valid_q;
  logic signed [vrp_pkg::PW-1:0]         ac_q, bs_q, as_q, bc_q;
  logic signed [vrp_pkg::QW-1:0]         c_q;
  logic signed [vrp_pkg::PW:0]           ra, rb;

  // Round half up, then floor-shift back to Q14
  always_comb begin
    ra = (vrp_pkg::PW+1)'(ac_q) - (vrp_pkg::PW+1)'(bs_q) + (vrp_pkg::PW+1)'(8192);
    rb = (vrp_pkg::PW+1)'(as_q) + (vrp_pkg::PW+1)'(bc_q) + (vrp_pkg::PW+1)'(8192);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
      valid_o <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q <= a_i * trig_i.cos_v;
      bs_q <= b_i * trig_i.sin_v;
      as_q <= a_i * trig_i.sin_v;
      bc_q <= b_i * trig_i.cos_v;
      c_q  <= c_i;
      a_o  <= ra[vrp_pkg::QW+vrp_pkg::FRAC_BITS-1:vrp_pkg::FRAC_BITS];
      b_o  <= rb[vrp_pkg::QW+vrp_pkg::FRAC_BITS-1:vrp_pkg::FRAC_BITS];
      c_o  <= c_q;
    end
  end

endmodule

`default_nettype wire

/* rtl/vrp_project.sv */
// Perspective projection: depth shift, numerator, pipelined restoring divide, saturation.
`default_nettype none

module vrp_project (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [vrp_pkg::QW-1:0]    px_i,
  input  logic signed [vrp_pkg::QW-1:0]    py_i,
  input  logic signed [vrp_pkg::QW-1:0]    pz_i,
  input  vrp_pkg::view_t                   view_i,
  output logic                             valid_o,
  output vrp_pkg::pixel_t                  pixel_o
);

  localparam int ZW = vrp_pkg::ZW;
  localparam int NW = vrp_pkg::NW;
  localparam int RW = vrp_pkg::RW;
  localparam int QN = vrp_pkg::QUO_W;
  localparam int SW = vrp_pkg::SCREEN_W;
  localparam int OFFSET_PAD = vrp_pkg::OFFSET_W + 1;

  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [RW-1:0] rem;
    logic [QN-1:0] quo;
  } lane_t;

  // stage 1: depth shift and scaled coordinates
  logic                 v1_q;
  logic signed [ZW-1:0] zq1_q;
  logic signed [NW-1:0] x1_q, y1_q;
  // stage 2: offset products
  logic                 v2_q, behind2_q;
  logic signed [ZW-1:0] zq2_q;
  logic signed [NW-1:0] x2_q, y2_q, px2_q, py2_q;
  // stage 3: numerators
  logic                 v3_q, behind3_q;
  logic signed [ZW-1:0] zq3_q;
  logic signed [NW-1:0] nx3_q, ny3_q;
  // stage 4: magnitudes
  logic                 v4_q, behind4_q, negx4_q, negy4_q;
  logic [NW-1:0]        mx4_q, my4_q;
  logic [ZW-2:0]        d4_q;
  // divide stages
  logic                 vd_q      [QN+1];
  logic                 behind_q  [QN+1];
  logic [ZW-2:0]        dv_q      [QN+1];
  lane_t                lx_q      [QN+1];
  lane_t                ly_q      [QN+1];

  logic signed [ZW+OFFSET_PAD-1:0] prodx, prody;
  logic [SW:0]          satx, saty;

  function automatic lane_t div_step(input lane_t l, input logic [ZW-2:0] d, input int sh);
    logic [RW-1:0] ds;
    lane_t         r;
    ds = RW'(d) << sh;
    r  = l;
    if (l.rem >= ds) begin
      r.rem = l.rem - ds;
      r.quo = {l.quo[QN-2:0], 1'b1};
    end else begin
      r.quo = {l.quo[QN-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic lane_t div_start(input logic neg, input logic [NW-1:0] mag,
                                      input logic [ZW-2:0] d);
    lane_t r;
    r.neg = neg;
    r.rem = RW'(mag);
    r.ovf = (RW'(mag) >= (RW'(d) << QN));
    r.quo = '0;
    return r;
  endfunction

  // Truncated quotient to a signed 16-bit result, with clip flag on top
  function automatic logic [SW:0] saturate(input lane_t l);
    logic signed [QN:0] v;
    logic [SW:0]        r;
    v = l.neg ? -signed'({1'b0, l.quo}) : signed'({1'b0, l.quo});
    if (l.neg && (l.ovf || l.quo > (QN'(1) << (SW - 1))))
      r = {1'b1, vrp_pkg::SAT_MIN};
    else if (!l.neg && (l.ovf || l.quo > QN'(vrp_pkg::SAT_MAX)))
      r = {1'b1, vrp_pkg::SAT_MAX};
    else
      r = {1'b0, v[SW-1:0]};
    return r;
  endfunction

  always_comb begin
    prodx = $signed({1'b0, view_i.offset_x}) * zq1_q;
    prody = $signed({1'b0, view_i.offset_y}) * zq1_q;
    satx  = saturate(lx_q[QN]);
    saty  = saturate(ly_q[QN]);
  end

  // Valid chain, including one valid bit per divide stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      for (int k = 0; k <= QN; k++) vd_q[k] <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      vd_q[0] <= v4_q;
      for (int k = 0; k < QN; k++) vd_q[k+1] <= vd_q[k];
      valid_o <= vd_q[QN];
    end
  end

  // Projection stages and divider datapath
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zq1_q <= ZW'(pz_i) + signed'(ZW'({view_i.depth, {vrp_pkg::FRAC_BITS{1'b0}}}));
      x1_q  <= NW'(px_i) <<< vrp_pkg::PROJ_SHIFT;
      y1_q  <= NW'(py_i) <<< vrp_pkg::PROJ_SHIFT;

      zq2_q     <= zq1_q;
      behind2_q <= (zq1_q <= 0);
      x2_q      <= x1_q;
      y2_q      <= y1_q;
      px2_q     <= NW'(prodx);
      py2_q     <= NW'(prody);

      zq3_q     <= zq2_q;
      behind3_q <= behind2_q;
      nx3_q     <= x2_q + px2_q;
      ny3_q     <= y2_q + py2_q;

      behind4_q <= behind3_q;
      d4_q      <= zq3_q[ZW-2:0];
      negx4_q   <= nx3_q[NW-1];
      negy4_q   <= ny3_q[NW-1];
      mx4_q     <= nx3_q[NW-1] ? NW'(-nx3_q) : NW'(nx3_q);
      my4_q     <= ny3_q[NW-1] ? NW'(-ny3_q) : NW'(ny3_q);

      behind_q[0] <= behind4_q;
      dv_q[0]     <= d4_q;
      lx_q[0]     <= div_start(negx4_q, mx4_q, d4_q);
      ly_q[0]     <= div_start(negy4_q, my4_q, d4_q);

      // One quotient bit per stage, most significant first
      for (int k = 0; k < QN; k++) begin
        behind_q[k+1] <= behind_q[k];
        dv_q[k+1]     <= dv_q[k];
        lx_q[k+1]     <= div_step(lx_q[k], dv_q[k], QN - 1 - k);
        ly_q[k+1]     <= div_step(ly_q[k], dv_q[k], QN - 1 - k);
      end

      // Output word; behind the viewer gives zeros
      pixel_o.behind_viewer <= behind_q[QN];
      if (behind_q[QN]) begin
        pixel_o.screen_x <= '0;
        pixel_o.screen_y <= '0;
        pixel_o.clipped  <= 1'b0;
      end else begin
        pixel_o.screen_x <= satx[SW-1:0];
        pixel_o.screen_y <= saty[SW-1:0];
        pixel_o.clipped  <= satx[SW] | saty[SW];
      end
    end
  end

endmodule

`default_nettype wire
